/* hdl/ascfmt_pkg.sv */
package ascfmt_pkg;

  // Command codes
  localparam logic [1:0] CMD_LIT  = 2'd0;
  localparam logic [1:0] CMD_DEC  = 2'd1;
  localparam logic [1:0] CMD_HEX  = 2'd2;
  localparam logic [1:0] CMD_NULL = 2'd3;

  localparam int unsigned CountW  = 31;
  localparam int unsigned NumW    = 32;
  localparam int unsigned DecDigs = 10;
  localparam int unsigned HexDigs = 8;
  localparam int unsigned DigW    = 4 * DecDigs;
  localparam int unsigned NdigW   = 4;
  localparam int unsigned BitCntW = 5;
  localparam int unsigned NullLen = 6;

  localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};

  typedef struct packed {
    logic            start_of_call;
    logic [1:0]      command;
    logic [7:0]      byte_value;
    logic [NumW-1:0] number;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        char_out;
    logic [CountW-1:0] running_count;
    logic              last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic conv;
    logic skip;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic conv_done;
    logic skip_done;
    logic emit_last;
    logic out_free;
  } dp_status_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SKIP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  // Lowercase hex digit character
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) c = 8'h30 + {4'd0, nib};
    else             c = 8'h57 + {4'd0, nib};
    return c;
  endfunction

  // "(null)" indexed by characters still to send
  function automatic logic [7:0] null_char(input logic [NdigW-1:0] left);
    logic [7:0] c;
    case (left)
      4'd6:    c = 8'h28;
      4'd5:    c = 8'h6e;
      4'd4:    c = 8'h75;
      4'd3:    c = 8'h6c;
      4'd2:    c = 8'h6c;
      default: c = 8'h29;
    endcase
    return c;
  endfunction

endpackage

/* hdl/ascfmt_ctrl.sv */
module ascfmt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [1:0]            command_i,
  output logic                  in_ready_o,
  input  ascfmt_pkg::dp_status_t status_i,
  output ascfmt_pkg::dp_cmd_t   cmd_o
);

  ascfmt_pkg::state_e state_q, state_d;

  assign in_ready_o = (state_q == ascfmt_pkg::ST_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    unique case (state_q)
      ascfmt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (command_i)
            ascfmt_pkg::CMD_DEC: state_d = ascfmt_pkg::ST_CONV;
            ascfmt_pkg::CMD_HEX: state_d = ascfmt_pkg::ST_SKIP;
            default:             state_d = ascfmt_pkg::ST_EMIT;
          endcase
        end
      end
      ascfmt_pkg::ST_CONV: begin
        cmd_o.conv = 1'b1;
        if (status_i.conv_done) state_d = ascfmt_pkg::ST_SKIP;
      end
      ascfmt_pkg::ST_SKIP: begin
        if (status_i.skip_done) state_d = ascfmt_pkg::ST_EMIT;
        else                    cmd_o.skip = 1'b1;
      end
      ascfmt_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.emit_last) state_d = ascfmt_pkg::ST_IDLE;
        end
      end
      default: state_d = ascfmt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ascfmt_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

endmodule

/* hdl/ascfmt_dp.sv */
module ascfmt_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ascfmt_pkg::in_item_t   in_data_i,
  input  ascfmt_pkg::dp_cmd_t    cmd_i,
  output ascfmt_pkg::dp_status_t status_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output ascfmt_pkg::out_item_t  out_data_o
);

  localparam int unsigned DigW  = ascfmt_pkg::DigW;
  localparam int unsigned NumW  = ascfmt_pkg::NumW;
  localparam int unsigned NdigW = ascfmt_pkg::NdigW;
  localparam int unsigned CntW  = ascfmt_pkg::CountW;

  logic [1:0]                      op_q;
  logic [7:0]                      byte_q;
  logic                            neg_q;
  logic [NumW-1:0]                 bin_q;
  logic [DigW-1:0]                 dig_q;
  logic [NdigW-1:0]                ndig_q;
  logic [ascfmt_pkg::BitCntW-1:0]  bitcnt_q;
  logic [CntW-1:0]                 count_q;
  logic                            out_valid_q;
  ascfmt_pkg::out_item_t           out_q;

  logic [DigW-1:0]  dig_adj;
  logic [NumW-1:0]  mag;
  logic [3:0]       top_nib;
  logic [7:0]       ch;
  logic [CntW-1:0]  count_inc;
  logic             is_num;

  assign top_nib = dig_q[DigW-1 -: 4];
  assign is_num  = (op_q == ascfmt_pkg::CMD_DEC) || (op_q == ascfmt_pkg::CMD_HEX);
  assign mag     = in_data_i.number[NumW-1] ? (~in_data_i.number + 1'b1) : in_data_i.number;

  // Double-dabble correction: each BCD digit of 5 or more gets 3 added
  always_comb begin
    for (int i = 0; i < ascfmt_pkg::DecDigs; i++) begin
      if (dig_q[4*i +: 4] >= 4'd5) dig_adj[4*i +: 4] = dig_q[4*i +: 4] + 4'd3;
      else                          dig_adj[4*i +: 4] = dig_q[4*i +: 4];
    end
  end

  // Character for the current emit step
  always_comb begin
    case (op_q)
      ascfmt_pkg::CMD_LIT:  ch = byte_q;
      ascfmt_pkg::CMD_NULL: ch = ascfmt_pkg::null_char(ndig_q);
      default:              ch = neg_q ? 8'h2d : ascfmt_pkg::hex_char(top_nib);
    endcase
  end

  assign count_inc = (count_q == ascfmt_pkg::COUNT_MAX) ? count_q : count_q + 1'b1;

  assign status_o.conv_done = (bitcnt_q == '0);
  assign status_o.skip_done = (ndig_q <= NdigW'(1)) || (top_nib != 4'd0);
  assign status_o.emit_last = !neg_q && (ndig_q == NdigW'(1));
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= in_data_i.command;
      byte_q   <= in_data_i.byte_value;
      bin_q    <= mag;
      bitcnt_q <= '1;
      neg_q    <= (in_data_i.command == ascfmt_pkg::CMD_DEC) && in_data_i.number[NumW-1];
      case (in_data_i.command)
        ascfmt_pkg::CMD_DEC: begin
          dig_q  <= '0;
          ndig_q <= NdigW'(ascfmt_pkg::DecDigs);
        end
        ascfmt_pkg::CMD_HEX: begin
          dig_q  <= {in_data_i.number, {(DigW-NumW){1'b0}}};
          ndig_q <= NdigW'(ascfmt_pkg::HexDigs);
        end
        ascfmt_pkg::CMD_NULL: begin
          dig_q  <= '0;
          ndig_q <= NdigW'(ascfmt_pkg::NullLen);
        end
        default: begin
          dig_q  <= '0;
          ndig_q <= NdigW'(1);
        end
      endcase
    end else if (cmd_i.conv) begin
      {dig_q, bin_q} <= {dig_adj[DigW-2:0], bin_q, 1'b0};
      bitcnt_q       <= bitcnt_q - 1'b1;
    end else if (cmd_i.skip) begin
      dig_q  <= {dig_q[DigW-5:0], 4'd0};
      ndig_q <= ndig_q - 1'b1;
    end else if (cmd_i.emit) begin
      if (neg_q) begin
        neg_q <= 1'b0;
      end else begin
        ndig_q <= ndig_q - 1'b1;
        if (is_num) dig_q <= {dig_q[DigW-5:0], 4'd0};
      end
    end
  end

  // Running character count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.load && in_data_i.start_of_call) begin
      count_q <= '0;
    end else if (cmd_i.emit) begin
      count_q <= count_inc;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.char_out      <= ch;
      out_q.running_count <= count_inc;
      out_q.last          <= status_o.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hdl/integer_to_ascii_formatter.sv */
// Integer to ASCII formatter: printf-style back end.
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one formatting
// request per transaction: a literal byte, a signed decimal, an unsigned
// lowercase hex value or the "(null)" marker. The output channel
// (out_valid_o/out_ready_i/out_data_o) gives one character per transaction
// with the running count since the last start and a last flag on the
// final character of each request.
// One request is worked on at a time; in_ready_o is high only when idle.
// Work per request, after the accept: literal, one character; null, six
// characters; hex, up to 7 leading-zero skips, a skip exit and 1..8
// characters; decimal, 32 binary-to-BCD shift steps, a skip exit, up to
// 9 skips and 1..11 characters. The character stage sends one character
// per cycle while the receiver takes them, each character being
// registered in the output register.
// A stalled receiver holds the output register and the controller waits
// in its emit state; no character is lost or repeated.
// Reset clears the controller, the output valid and the character count.
module integer_to_ascii_formatter (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ascfmt_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ascfmt_pkg::out_item_t out_data_o
);

  ascfmt_pkg::dp_cmd_t    dp_cmd;
  ascfmt_pkg::dp_status_t dp_status;

  ascfmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (in_data_i.command),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  ascfmt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
